// File: rtl/itra_pkg.sv
package itra_pkg;

  localparam int unsigned PC_W = 3;

  localparam logic [6:0] CHAR_ZERO = 7'd48;
  localparam logic [6:0] CHAR_A = 7'd97;
  localparam logic [5:0] DECIMAL_DIGITS = 6'd10;
  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd16;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_START_LOW,
    JMP_BIT_NZ,
    JMP_QUOT_NZ,
    JMP_MORE
  } jmp_cond_t;

  typedef enum logic [PC_W-1:0] {
    STEP_IDLE     = 3'd0,
    STEP_DIV_INIT = 3'd1,
    STEP_DIV_BIT  = 3'd2,
    STEP_STORE    = 3'd3,
    STEP_RD_INIT  = 3'd4,
    STEP_RD_FIRST = 3'd5,
    STEP_EMIT     = 3'd6,
    STEP_DONE     = 3'd7
  } step_t;

  typedef struct packed {
    logic      ld_value;
    logic      div_init;
    logic      div_step;
    logic      store;
    logic      rd_init;
    logic      rd_issue;
    logic      emit;
    jmp_cond_t cond;
    step_t     target;
  } ctl_word_t;

  typedef struct packed {
    logic start_low;
    logic bit_nz;
    logic quot_nz;
    logic more;
  } status_t;

  function automatic ctl_word_t itra_rom(input step_t pc);
    ctl_word_t w;
    w = '{default: '0, cond: JMP_NONE, target: STEP_IDLE};
    unique case (pc)
      STEP_IDLE: begin
        w.ld_value = 1'b1;
        w.cond = JMP_START_LOW;
        w.target = STEP_IDLE;
      end
      STEP_DIV_INIT: begin
        w.div_init = 1'b1;
      end
      STEP_DIV_BIT: begin
        w.div_step = 1'b1;
        w.cond = JMP_BIT_NZ;
        w.target = STEP_DIV_BIT;
      end
      STEP_STORE: begin
        w.store = 1'b1;
        w.cond = JMP_QUOT_NZ;
        w.target = STEP_DIV_INIT;
      end
      STEP_RD_INIT: begin
        w.rd_init = 1'b1;
      end
      STEP_RD_FIRST: begin
        w.rd_issue = 1'b1;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.rd_issue = 1'b1;
        w.cond = JMP_MORE;
        w.target = STEP_EMIT;
      end
      STEP_DONE: begin
        w.cond = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
    if (d < DECIMAL_DIGITS) begin
      return CHAR_ZERO + {1'b0, d};
    end
    return CHAR_A + {1'b0, d - DECIMAL_DIGITS};
  endfunction

endpackage

// File: rtl/itra_seq.sv
module itra_seq (
  input  logic                clk,
  input  logic                rst,
  input  itra_pkg::status_t   status,
  output itra_pkg::ctl_word_t ctl,
  output logic                busy
);

  itra_pkg::step_t pc;
  itra_pkg::step_t pc_next;
  logic            take;

  assign ctl = itra_pkg::itra_rom(pc);
  assign busy = (pc != itra_pkg::STEP_IDLE);

  always_comb begin
    unique case (ctl.cond)
      itra_pkg::JMP_NONE:      take = 1'b0;
      itra_pkg::JMP_ALWAYS:    take = 1'b1;
      itra_pkg::JMP_START_LOW: take = status.start_low;
      itra_pkg::JMP_BIT_NZ:    take = status.bit_nz;
      itra_pkg::JMP_QUOT_NZ:   take = status.quot_nz;
      itra_pkg::JMP_MORE:      take = status.more;
      default:                 take = 1'b1;
    endcase
    if (take) begin
      pc_next = ctl.target;
    end else begin
      pc_next = itra_pkg::step_t'(pc + itra_pkg::PC_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= itra_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: rtl/itra_dpath.sv
module itra_dpath #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  itra_pkg::ctl_word_t   ctl,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [5:0]            radix,
  output itra_pkg::status_t     status,
  output logic                  strobe,
  output logic [6:0]            digit_char,
  output logic                  last
);

  localparam int unsigned BW = $clog2(VALUE_BITS);
  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned KW = $clog2(MAX_DIGITS + 1);
  localparam logic [AW-1:0] PTR_TOP = AW'(MAX_DIGITS - 1);

  logic [VALUE_BITS-1:0] quotient;
  logic [5:0]            rem;
  logic [BW-1:0]         bit_cnt;
  logic [AW-1:0]         wr_ptr;
  logic [AW-1:0]         rd_ptr;
  logic [KW-1:0]         digit_count;
  logic [KW-1:0]         left;
  logic [5:0]            rd_data;
  logic [5:0]            digit_store [MAX_DIGITS];

  logic [6:0] trial;
  logic       fits;

  // one restoring division bit: shift the quotient register's top bit into the remainder
  assign trial = {rem, quotient[VALUE_BITS-1]};
  assign fits = (trial >= {1'b0, radix});

  assign status.start_low = !start;
  assign status.bit_nz = (bit_cnt != '0);
  assign status.quot_nz = (quotient != '0);
  assign status.more = (left != KW'(1));

  assign strobe = ctl.emit;
  assign digit_char = itra_pkg::digit_to_ascii(rd_data);
  assign last = (left == KW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      quotient <= '0;
      digit_count <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      left <= '0;
      bit_cnt <= '0;
    end else begin
      if (ctl.ld_value && start) begin
        quotient <= value;
        digit_count <= '0;
        wr_ptr <= '0;
      end
      if (ctl.div_init) begin
        bit_cnt <= BW'(VALUE_BITS - 1);
      end
      if (ctl.div_step) begin
        quotient <= {quotient[VALUE_BITS-2:0], fits};
        bit_cnt <= bit_cnt - BW'(1);
      end
      if (ctl.store) begin
        // wrap the write pointer: a full store drops its oldest entry
        wr_ptr <= (wr_ptr == PTR_TOP) ? '0 : wr_ptr + AW'(1);
        if (digit_count != KW'(MAX_DIGITS)) begin
          digit_count <= digit_count + KW'(1);
        end
      end
      if (ctl.rd_init) begin
        rd_ptr <= (wr_ptr == '0) ? PTR_TOP : wr_ptr - AW'(1);
        left <= digit_count;
      end
      if (ctl.rd_issue) begin
        rd_ptr <= (rd_ptr == '0) ? PTR_TOP : rd_ptr - AW'(1);
      end
      if (ctl.emit) begin
        left <= left - KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      rem <= '0;
    end else if (ctl.div_step) begin
      rem <= fits ? 6'(trial - {1'b0, radix}) : trial[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.store) begin
      digit_store[wr_ptr] <= rem;
    end
    if (ctl.rd_issue) begin
      rd_data <= digit_store[rd_ptr];
    end
  end

endmodule

// File: rtl/integer_to_radix_ascii.sv
// Converts one non-negative integer to ASCII digits in the radix held in the
// out_base register ('0'-'9', then 'a'-'z'), most significant digit first.
// Raise start with value while busy is low; that beat is taken and busy stays
// high until the last character has gone out. Each character appears for one
// cycle with strobe high, and the final one carries last. The receiver cannot
// stall: capture every strobe beat. A zero value yields the single digit '0'.
// The restoring divider yields one quotient bit per cycle for each digit, and
// the readout sends one digit per cycle. out_base values below 2 act as radix
// 2 and above 36 as radix 36. cfg_ready is always high; write out_base only
// while busy is low.
module integer_to_radix_ascii #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  strobe,
  output logic [6:0]            digit_char,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [5:0]            cfg_data
);

  logic [5:0] out_base;
  logic [5:0] radix;

  itra_pkg::ctl_word_t ctl;
  itra_pkg::status_t   status;

  assign cfg_ready = 1'b1;

  // hold the register; clamp it to the legal radix range on use
  always_ff @(posedge clk) begin
    if (rst) begin
      out_base <= itra_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      out_base <= cfg_data;
    end
  end

  always_comb begin
    if (out_base < itra_pkg::RADIX_MIN) begin
      radix = itra_pkg::RADIX_MIN;
    end else if (out_base > itra_pkg::RADIX_MAX) begin
      radix = itra_pkg::RADIX_MAX;
    end else begin
      radix = out_base;
    end
  end

  // microprogram: step counter plus control-word table with jumps
  itra_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl),
    .busy   (busy)
  );

  // divider, digit store and readout pointers
  itra_dpath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .start      (start),
    .value      (value),
    .radix      (radix),
    .status     (status),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last       (last)
  );

endmodule
